>>> src/plr_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Used by plr_front, plr_div_stage and piecewise_linear_interpolator_unit.
package plr_pkg;

  // request kinds carried on in_tuser
  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // result status codes carried on out_tuser
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SEGMENT = 2'd1;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

  // point count width (counts up to 511 breakpoints)
  localparam int NCW = 9;
  // divider: quotient bits, bits retired per stage, remainder width
  localparam int QW    = 33;
  localparam int DSTEP = 3;
  localparam int RW    = 35;
  localparam int DSTAGES = QW / DSTEP;

  // per-item sideband that rides along the pipeline
  typedef struct packed {
    logic        valid;
    logic        direct;  // value is final, no division needed
    logic [1:0]  status;
    logic [31:0] val;     // direct value, or y0 of the segment
    logic        neg;     // interpolation step is subtracted
  } side_t;

  // segment differences after selection
  typedef struct packed {
    side_t      side;
    logic [32:0] dy;
    logic [32:0] dq;
    logic [32:0] dx;
  } seg_t;

  // divider working set
  typedef struct packed {
    side_t         side;
    logic [RW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic [RW-1:0] dd;
  } div_t;

endpackage

>>> src/piecewise_linear_interpolator_unit.sv
// Piecewise linear interpolation table, top level.
// Depends on plr_pkg, plr_front and plr_div_stage.
//
// Use: load breakpoints with write items (in_tuser = 1), set the number of
// points in use through the cfg_ channel, then send evaluate items
// (in_tuser = 0). Each evaluate item yields one result item on out_;
// write items yield none and are seen by every item accepted after them.
// Pipeline: an evaluate item passes through 16 register stages on its way
// to out_: two compare/select stages, multiply, numerator add, 11 divider
// stages, output register. Throughput: one item per cycle while the
// receiver does not stall; the long division is a pipelined restoring
// divider retiring 3 quotient bits per stage.
// The pipeline advances as a whole while the output register is empty or
// being taken; when the receiver stalls, in_tready drops and every stage
// holds, nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets the point
// count to 0. Table contents are not cleared and must be written before
// they are used. cfg_ready is always high; write it only when idle.
module piecewise_linear_interpolator_unit import plr_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // point_index, point_x, point_y, query_x, zero pad
  input  logic [0:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // result_value
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data    // points_in_use
);

  logic [4:0]     pts_r;
  logic [NCW-1:0] n_eff;
  logic           en, acc;
  seg_t           seg;
  side_t          s3_side_r, s3_side_nxt;
  logic [32:0]    ady, adq;
  logic [65:0]    s3_prod_r;
  logic [32:0]    s3_ad_r;
  div_t           s4_r, s4_nxt;
  div_t           dv [DSTAGES+1];
  logic           out_valid_r;
  logic [31:0]    out_val_r, out_val_nxt;
  logic [1:0]     out_st_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else if (cfg_valid) begin
      pts_r <= cfg_data;
    end
  end

  assign n_eff = ({4'b0, pts_r} > NCW'(MAX_POINTS)) ? NCW'(MAX_POINTS) : {4'b0, pts_r};

  // global advance
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && in_tready;

  plr_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .wr_en       (acc && in_tuser[0] == REQ_WRITE),
    .ev_en       (acc && in_tuser[0] == REQ_EVAL),
    .point_index (in_tdata[3:0]),
    .point_x     (in_tdata[35:4]),
    .point_y     (in_tdata[67:36]),
    .query_x     (in_tdata[99:68]),
    .n_pts       (n_eff),
    .seg_o       (seg)
  );

  // stage 3: magnitudes, sign and product
  assign ady = seg.dy[32] ? 33'(-seg.dy) : seg.dy;
  assign adq = seg.dq[32] ? 33'(-seg.dq) : seg.dq;

  always_comb begin
    s3_side_nxt     = seg.side;
    s3_side_nxt.neg = (seg.dy[32] != seg.dq[32]) != seg.dx[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.valid <= 1'b0;
    end else if (en) begin
      s3_side_r <= s3_side_nxt;
      s3_prod_r <= ady * adq;
      s3_ad_r   <= seg.dx[32] ? 33'(-seg.dx) : seg.dx;
    end
  end

  // stage 4: rounded numerator 2N + D over 2D
  always_comb begin
    logic [67:0] num;
    num = {1'b0, s3_prod_r, 1'b0} + {35'b0, s3_ad_r};
    s4_nxt.side = s3_side_r;
    s4_nxt.rem  = num[67:QW];
    s4_nxt.low  = num[QW-1:0];
    s4_nxt.quo  = '0;
    s4_nxt.dd   = {1'b0, s3_ad_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.side.valid <= 1'b0;
    end else if (en) begin
      s4_r <= s4_nxt;
    end
  end

  // divider chain
  assign dv[0] = s4_r;
  for (genvar g = 0; g < DSTAGES; g++) begin : g_div
    plr_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dv[g]),
      .d_o   (dv[g+1])
    );
  end

  // final add and saturation
  always_comb begin
    logic signed [34:0] sum;
    side_t              sd;
    sd  = dv[DSTAGES].side;
    sum = sd.neg ? {{3{sd.val[31]}}, sd.val} - {2'b0, dv[DSTAGES].quo}
                 : {{3{sd.val[31]}}, sd.val} + {2'b0, dv[DSTAGES].quo};
    if (sd.direct) begin
      out_val_nxt = sd.val;
    end else if (sum > 35'sd2147483647) begin
      out_val_nxt = 32'h7fff_ffff;
    end else if (sum < -35'sd2147483648) begin
      out_val_nxt = 32'h8000_0000;
    end else begin
      out_val_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[DSTAGES].side.valid;
      out_val_r   <= out_val_nxt;
      out_st_r    <= dv[DSTAGES].side.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_st_r;

  // a write item never enters the result path
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser[0] == REQ_WRITE |=> !u_front.s1_valid_r)
    else $error("write item entered result path");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_OK || out_tuser == ST_NO_SEGMENT ||
                   out_tuser == ST_ZERO_WIDTH)
    else $error("bad status code");

  // a stall freezes the divider input stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s4_r))
    else $error("pipeline moved during stall");

  // no input taken while the output waits
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during stall");

endmodule

>>> src/plr_front.sv
// Breakpoint table, query compares and segment selection (two register stages).
// Depends on plr_pkg.
module plr_front import plr_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           wr_en,
  input  logic           ev_en,
  input  logic [3:0]     point_index,
  input  logic [31:0]    point_x,
  input  logic [31:0]    point_y,
  input  logic [31:0]    query_x,
  input  logic [NCW-1:0] n_pts,
  output seg_t           seg_o
);

  logic signed [31:0] x_r [MAX_POINTS];
  logic signed [31:0] y_r [MAX_POINTS];
  logic signed [31:0] x_cmp [MAX_POINTS];

  logic                  wp_valid_r;
  logic [3:0]            wp_idx_r;
  logic signed [31:0]    wp_x_r;
  logic signed [31:0]    wp_y_r;

  logic                  s1_valid_r;
  logic signed [31:0]    s1_q_r;
  logic [MAX_POINTS-1:0] s1_ge_r, s1_le_r;
  logic [NCW-1:0]        s1_n_r;
  seg_t                  s2_r, s2_nxt;

  // pending write, held in these registers before it lands in the table so
  // that an evaluate item already in stage 1 still selects from the old table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_valid_r <= 1'b0;
    end else if (en) begin
      wp_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wp_idx_r <= point_index;
      wp_x_r   <= point_x;
      wp_y_r   <= point_y;
    end
  end

  // table writes, slot by slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (en && wp_valid_r && int'(wp_idx_r) == i) begin
        x_r[i] <= wp_x_r;
        y_r[i] <= wp_y_r;
      end
    end
  end

  // compare operands with the pending write bypassed in
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      x_cmp[i] = x_r[i];
      if (wp_valid_r && int'(wp_idx_r) == i) begin
        x_cmp[i] = wp_x_r;
      end
    end
  end

  // stage 1: compare query against every breakpoint
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= ev_en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r <= query_x;
      s1_n_r <= n_pts;
      for (int i = 0; i < MAX_POINTS; i++) begin
        s1_ge_r[i] <= $signed(query_x) >= x_cmp[i];
        s1_le_r[i] <= $signed(query_x) <= x_cmp[i];
      end
    end
  end

  // stage 2: pick the first bracketing segment, one-hot, or a direct value or status
  always_comb begin
    logic                  found;
    logic                  above;
    logic [MAX_POINTS-1:0] first, last;
    logic [31:0]           x0, x1, y0, y1, ylast;
    found = 1'b0;
    above = 1'b0;
    first = '0;
    last  = '0;
    x0 = '0; x1 = '0; y0 = '0; y1 = '0; ylast = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      last[i] = (int'(s1_n_r) - 1 == i);
      if (last[i]) begin
        ylast = ylast | y_r[i];
        above = above | s1_ge_r[i];
      end
    end
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (!found && (i + 1 < int'(s1_n_r)) &&
          ((s1_ge_r[i] && !s1_ge_r[i+1]) || (s1_le_r[i] && !s1_le_r[i+1]))) begin
        first[i] = 1'b1;
        found    = 1'b1;
      end
    end
    for (int i = 0; i < MAX_POINTS - 1; i++) begin
      if (first[i]) begin
        x0 = x0 | x_r[i];
        x1 = x1 | x_r[i+1];
        y0 = y0 | y_r[i];
        y1 = y1 | y_r[i+1];
      end
    end

    s2_nxt.side.valid  = s1_valid_r;
    s2_nxt.side.direct = 1'b1;
    s2_nxt.side.status = ST_OK;
    s2_nxt.side.val    = '0;
    s2_nxt.side.neg    = 1'b0;
    s2_nxt.dy = {y1[31], y1} - {y0[31], y0};
    s2_nxt.dq = {s1_q_r[31], s1_q_r} - {x0[31], x0};
    s2_nxt.dx = {x1[31], x1} - {x0[31], x0};
    if (s1_n_r == '0) begin
      s2_nxt.side.val = '0;
    end else if (s1_le_r[0]) begin
      s2_nxt.side.val = y_r[0];
    end else if (above) begin
      s2_nxt.side.val = ylast;
    end else if (!found) begin
      s2_nxt.side.status = ST_NO_SEGMENT;
    end else if (x0 == x1) begin
      s2_nxt.side.status = ST_ZERO_WIDTH;
    end else begin
      s2_nxt.side.direct = 1'b0;
      s2_nxt.side.val    = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.side.valid <= 1'b0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign seg_o = s2_r;

endmodule

>>> src/plr_div_stage.sv
// One register stage of the restoring divider, DSTEP quotient bits per stage.
// Depends on plr_pkg.
module plr_div_stage import plr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t d_i,
  output div_t d_o
);

  div_t d_r, d_nxt;

  // shift in a numerator bit, subtract where the divisor fits
  always_comb begin
    d_nxt = d_i;
    for (int k = 0; k < DSTEP; k++) begin
      d_nxt.rem = {d_nxt.rem[RW-2:0], d_nxt.low[QW-1]};
      d_nxt.low = {d_nxt.low[QW-2:0], 1'b0};
      if (d_nxt.rem >= d_nxt.dd) begin
        d_nxt.rem = d_nxt.rem - d_nxt.dd;
        d_nxt.quo = {d_nxt.quo[QW-2:0], 1'b1};
      end else begin
        d_nxt.quo = {d_nxt.quo[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.side.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for piecewise_linear_interpolator_unit.
// Depends on plr_pkg and the interpolator RTL; predicts every evaluate result
// from its own breakpoint table copy and compares the streamed results.
module testbench import plr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH  = 16;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } interp_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;

  // shadow state of the block
  longint       tbl_x [TBL_DEPTH];
  longint       tbl_y [TBL_DEPTH];
  logic [4:0]   pts_reg;
  interp_result_t expected_q[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rcv_hold_left = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  piecewise_linear_interpolator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // cycle cap
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rcv_hold_left > 0) begin
      rcv_hold_left = rcv_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    interp_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result item value=%h status=%0d", out_tdata, out_tuser);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tdata !== exp_r.value || out_tuser !== exp_r.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     exp_r.value, exp_r.status, out_tdata, out_tuser);
        end
      end
    end
  end

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // interpolated value of the shadow table at q
  function automatic interp_result_t interpolate_at(input longint q);
    interp_result_t r;
    int n;
    longint x0, x1, y0, dy, dq, dx, res;
    logic [127:0] num, den, quo;
    bit neg;
    r.value = '0;
    r.status = ST_OK;
    n = (pts_reg > TBL_DEPTH) ? TBL_DEPTH : pts_reg;
    if (n == 0) return r;
    if (q <= tbl_x[0]) begin
      r.value = tbl_y[0][31:0];
      return r;
    end
    if (q >= tbl_x[n-1]) begin
      r.value = tbl_y[n-1][31:0];
      return r;
    end
    for (int i = 0; i + 1 < n; i++) begin
      x0 = tbl_x[i];
      x1 = tbl_x[i+1];
      if ((q >= x0 && q < x1) || (q <= x0 && q > x1)) begin
        y0 = tbl_y[i];
        dy = tbl_y[i+1] - y0;
        dq = q - x0;
        dx = x1 - x0;
        if (dx == 0) begin
          r.status = ST_ZERO_WIDTH;
          return r;
        end
        neg = ((dy < 0) != (dq < 0)) != (dx < 0);
        // round half away from zero: (2N + D) / 2D
        num = {64'd0, magnitude(dy)} * {64'd0, magnitude(dq)};
        num = (num << 1) + {64'd0, magnitude(dx)};
        den = {64'd0, magnitude(dx)} << 1;
        quo = num / den;
        res = neg ? y0 - longint'(quo[63:0]) : y0 + longint'(quo[63:0]);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        r.value = res[31:0];
        return r;
      end
    end
    r.status = ST_NO_SEGMENT;
    return r;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(input logic kind, input logic [3:0] slot,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] qx);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, qx, py, px, slot};
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_WRITE) begin
      tbl_x[slot] = longint'(signed'(px));
      tbl_y[slot] = longint'(signed'(py));
    end else begin
      expected_q.push_back(interpolate_at(longint'(signed'(qx))));
    end
  endtask

  task automatic eval_at(input logic [31:0] qx);
    send_item(REQ_EVAL, 4'($urandom), $urandom, $urandom, qx);
  endtask

  task automatic write_point(input int slot, input logic [31:0] px, input logic [31:0] py);
    send_item(REQ_WRITE, slot[3:0], px, py, $urandom);
  endtask

  // stop offering and let every pending result come out
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_points(input logic [4:0] n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pts_reg = n;
  endtask

  // fill all slots: 0 ascending, 1 descending, 2 unsorted, 3 full-range extremes
  task automatic load_table(input int shape);
    longint x, step;
    x = (shape == 1) ? 64'sd2000000000 : -64'sd2000000000;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      step = $urandom_range(1, 250000000);
      if ($urandom_range(3) == 0) step = $urandom_range(1, 4);
      case (shape)
        0: begin
          write_point(i, x[31:0], $urandom);
          x = x + step;
        end
        1: begin
          write_point(i, x[31:0], $urandom);
          x = x - step;
        end
        2: write_point(i, $urandom, $urandom);
        default: begin
          write_point(i, (i % 2) ? 32'h7fffffff : 32'h80000000,
                      (i % 3) ? 32'h80000000 : 32'h7fffffff);
        end
      endcase
    end
  endtask

  // query picked near a breakpoint, inside the table span, or anywhere
  function automatic logic [31:0] pick_query();
    int k;
    longint q;
    k = $urandom_range(15);
    case ($urandom_range(3))
      0: q = tbl_x[k] + $signed($urandom_range(6)) - 3;
      1: q = tbl_x[k] + ((tbl_x[(k + 1) % TBL_DEPTH] - tbl_x[k]) *
                         longint'($urandom_range(1000))) / 1000;
      default: q = longint'(signed'(32'($urandom)));
    endcase
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic test_directed;
    set_points(5'd0);
    eval_at(32'h00000000);
    eval_at(32'h80000000);
    load_table(3);
    set_points(5'd16);
    eval_at(32'h80000000);
    eval_at(32'h7fffffff);
    eval_at(32'h00000000);
    // ascending table with min and max ends
    write_point(0, 32'h80000000, 32'h7fffffff);
    write_point(1, 32'h00000000, 32'h80000000);
    write_point(2, 32'h00010000, 32'h00030000);
    write_point(3, 32'h7fffffff, 32'hffff0000);
    set_points(5'd4);
    eval_at(32'h80000000);
    eval_at(32'h80000001);
    eval_at(32'hc0000000);
    eval_at(32'h00000000);
    eval_at(32'h00008000);
    eval_at(32'h00018000);
    eval_at(32'h7ffffffe);
    eval_at(32'h7fffffff);
    set_points(5'd1);
    eval_at(32'h12345678);
    set_points(5'd31);
    eval_at(32'h00004000);
    set_points(5'd17);
    eval_at(32'hfffffff0);
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
    int done;
    logic [4:0] n;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(7))
        0: n = 5'd0;
        1: n = 5'd1;
        2: n = 5'd16;
        3: n = 5'd31;
        default: n = 5'($urandom_range(2, 31));
      endcase
      set_points(n);
      load_table($urandom_range(9) < 7 ? $urandom_range(1) : $urandom_range(2, 3));
      repeat (40) begin
        if ($urandom_range(19) == 0)
          write_point($urandom_range(15), $urandom, $urandom);
        else
          eval_at(pick_query());
        done++;
      end
    end
  endtask

  task automatic test_backpressure;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_points(5'd16);
    load_table(0);
    rcv_hold_left = 300;
    repeat (60) eval_at(pick_query());
    drain();
  endtask

  initial begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_x[i] = 0;
      tbl_y[i] = 0;
    end
    pts_reg = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(6, 56, 400);
    test_random_phase(56, 6, 400);
    test_backpressure();
    test_random_phase(0, 0, 400);
    drain();
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
